>>> rtl/core/tsrl_pkg.sv
// Package for the timestamp range log store: widths, status codes, state
// and cell control types, granularity masks. No dependencies.
`default_nettype none

package tsrl_pkg;

    localparam int KEY_W  = 40;
    localparam int ID_W   = 31;
    localparam int ST_W   = 3;
    localparam int GRAN_W = 3;

    localparam logic [ST_W-1:0] ST_NEW      = 3'd0;
    localparam logic [ST_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
    localparam logic [ST_W-1:0] ST_MATCH    = 3'd3;
    localparam logic [ST_W-1:0] ST_NONE     = 3'd4;

    localparam logic OP_PUT      = 1'b0;
    localparam logic OP_RETRIEVE = 1'b1;

    localparam logic [GRAN_W-1:0] GR_YEAR   = 3'd0;
    localparam logic [GRAN_W-1:0] GR_MONTH  = 3'd1;
    localparam logic [GRAN_W-1:0] GR_DAY    = 3'd2;
    localparam logic [GRAN_W-1:0] GR_HOUR   = 3'd3;
    localparam logic [GRAN_W-1:0] GR_MINUTE = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REPLACE,
        CELL_ROTATE
    } t_cell_op;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_entry;

    typedef struct packed {
        t_cell_op         op;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_cell_ctl;

    // key bits kept at each granularity; unknown codes act as second
    function automatic logic [KEY_W-1:0] gran_mask(input logic [GRAN_W-1:0] g);
        logic [KEY_W-1:0] m;
        unique case (g)
            GR_YEAR:   m = 40'hFFFC000000;
            GR_MONTH:  m = 40'hFFFFC00000;
            GR_DAY:    m = 40'hFFFFFE0000;
            GR_HOUR:   m = 40'hFFFFFFF000;
            GR_MINUTE: m = 40'hFFFFFFFFC0;
            default:   m = 40'hFFFFFFFFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/tsrl_if.sv
// Word channels of the timestamp range log store: request and result.
// Depends on tsrl_pkg for field widths.
`default_nettype none

interface tsrl_in_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [tsrl_pkg::ID_W-1:0]   log_id;
    logic [tsrl_pkg::KEY_W-1:0]  stamp;
    logic [tsrl_pkg::KEY_W-1:0]  end_stamp;
    logic [tsrl_pkg::GRAN_W-1:0] granularity;

    modport source (output valid, operation, log_id, stamp, end_stamp, granularity,
                    input ready);
    modport sink   (input valid, operation, log_id, stamp, end_stamp, granularity,
                    output ready);
endinterface

interface tsrl_out_if;
    logic                      valid;
    logic                      ready;
    logic [tsrl_pkg::ID_W-1:0] result_id;
    logic [tsrl_pkg::ST_W-1:0] status;
    logic                      last;

    modport source (output valid, result_id, status, last, input ready);
    modport sink   (input valid, result_id, status, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/timestamp_range_log_store.sv
// Top level of the timestamp range log store: chain of tsrl_cell kept in
// ascending key order, scan sequencer and result register.
// Depends on tsrl_pkg, tsrl_if and tsrl_cell.
//
//   channel  dir  modport  word
//   i_in     in   sink     operation, log_id, stamp, end_stamp, granularity
//   o_out    out  source   result_id, status, last
//
// A put: every cell compares in parallel, then the chain shifts to insert,
// one cell takes the new id, or (full) nothing changes. A retrieve rotates
// the chain once round, CAPACITY steps, emitting matches from the head cell
// in key order, else a no-match word. A stalled result holds the rotation
// at a matching head. Reset clears the valid bits at once; no clearing pass.
`default_nettype none

module timestamp_range_log_store #(
    parameter int CAPACITY = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tsrl_in_if.sink    i_in,
    tsrl_out_if.source o_out
);
    import tsrl_pkg::*;

    localparam int CNT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int NUM_W = $clog2(CAPACITY + 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic             r_found, n_found;
    logic [KEY_W-1:0] r_lo, n_lo;
    logic [KEY_W-1:0] r_hi, n_hi;
    logic [KEY_W-1:0] r_mask, n_mask;
    logic             r_ov, n_ov;
    logic [ID_W-1:0]  r_res_id, n_res_id;
    logic [ST_W-1:0]  r_status, n_status;
    logic             r_last, n_last;

    t_cell_ctl     w_ctl;
    t_entry        w_ent [CAPACITY];
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_hit;
    logic          w_head_match;
    logic          w_next_match;
    logic          w_out_free;
    logic          w_acc;
    logic          w_step;
    logic [KEY_W-1:0] w_gmask;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            localparam int NXT = (gi + 1) % CAPACITY;
            t_entry w_prev;
            logic   w_prev_gt;
            if (gi == 0) begin : g_first
                assign w_prev    = '0;
                assign w_prev_gt = 1'b0;
            end else begin : g_rest
                assign w_prev    = w_ent[gi-1];
                assign w_prev_gt = w_gt[gi-1];
            end
            tsrl_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_prev    (w_prev),
                .i_prev_gt (w_prev_gt),
                .i_next    (w_ent[NXT]),
                .o_entry   (w_ent[gi]),
                .o_gt      (w_gt[gi]),
                .o_hit     (w_hit[gi])
            );
        end
        if (CAPACITY > 1) begin : g_look
            assign w_next_match = w_ent[1].valid && ((w_ent[1].key & r_mask) >= r_lo)
                                  && ((w_ent[1].key & r_mask) <= r_hi);
        end else begin : g_nolook
            assign w_next_match = 1'b0;
        end
    endgenerate

    assign w_head_match = w_ent[0].valid && ((w_ent[0].key & r_mask) >= r_lo)
                          && ((w_ent[0].key & r_mask) <= r_hi);
    assign w_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_out_free;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_step     = !w_head_match || w_out_free;
    assign w_gmask    = gran_mask(i_in.granularity);

    assign o_out.valid     = r_ov;
    assign o_out.result_id = r_res_id;
    assign o_out.status    = r_status;
    assign o_out.last      = r_last;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_num    = r_num;
        n_found  = r_found;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mask   = r_mask;
        n_ov     = r_ov && !o_out.ready;
        n_res_id = r_res_id;
        n_status = r_status;
        n_last   = r_last;
        w_ctl    = '{op: CELL_HOLD, key: i_in.stamp, id: i_in.log_id};

        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_in.operation == OP_PUT) begin
                    n_ov     = 1'b1;
                    n_res_id = '0;
                    n_last   = 1'b1;
                    if (|w_hit) begin
                        w_ctl.op = CELL_REPLACE;
                        n_status = ST_REPLACED;
                    end else if (r_num == NUM_W'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctl.op = CELL_INSERT;
                        n_status = ST_NEW;
                        n_num    = r_num + 1'b1;
                    end
                end else if (w_acc) begin
                    n_lo    = i_in.stamp & w_gmask;
                    n_hi    = i_in.end_stamp & w_gmask;
                    n_mask  = w_gmask;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_step) begin
                    w_ctl.op = CELL_ROTATE;
                    if (w_head_match) begin
                        n_ov     = 1'b1;
                        n_res_id = w_ent[0].id;
                        n_status = ST_MATCH;
                        n_last   = !w_next_match || (r_cnt == CNT_W'(CAPACITY - 1));
                        n_found  = 1'b1;
                    end
                    if (r_cnt == CNT_W'(CAPACITY - 1)) begin
                        n_state = (r_found || w_head_match) ? S_IDLE : S_FINISH;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_ov     = 1'b1;
                    n_res_id = '0;
                    n_status = ST_NONE;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_num   <= '0;
            r_found <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_num   <= n_num;
            r_found <= n_found;
            r_ov    <= n_ov;
        end
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mask   <= n_mask;
        r_res_id <= n_res_id;
        r_status <= n_status;
        r_last   <= n_last;
    end

endmodule

`default_nettype wire

>>> rtl/core/tsrl_cell.sv
// One cell of the sorted entry chain: holds one key/id pair, compares it
// against the put key and shifts to or from its neighbours. Uses tsrl_pkg.
`default_nettype none

module tsrl_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tsrl_pkg::t_cell_ctl i_ctl,
    input  wire tsrl_pkg::t_entry   i_prev,
    input  wire logic               i_prev_gt,
    input  wire tsrl_pkg::t_entry   i_next,
    output tsrl_pkg::t_entry        o_entry,
    output logic                    o_gt,
    output logic                    o_hit
);
    import tsrl_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [ID_W-1:0]  r_id;
    logic             n_valid;
    logic [KEY_W-1:0] n_key;
    logic [ID_W-1:0]  n_id;

    assign o_entry = '{valid: r_valid, key: r_key, id: r_id};
    assign o_gt    = !r_valid || (i_ctl.key < r_key);
    assign o_hit   = r_valid && (i_ctl.key == r_key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_id    = r_id;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (o_gt && !i_prev_gt) begin
                    n_valid = 1'b1;
                    n_key   = i_ctl.key;
                    n_id    = i_ctl.id;
                end else if (o_gt) begin
                    n_valid = i_prev.valid;
                    n_key   = i_prev.key;
                    n_id    = i_prev.id;
                end
            end
            CELL_REPLACE: begin
                if (o_hit) begin
                    n_id = i_ctl.id;
                end
            end
            CELL_ROTATE: begin
                n_valid = i_next.valid;
                n_key   = i_next.key;
                n_id    = i_next.id;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_key <= n_key;
        r_id  <= n_id;
    end

endmodule

`default_nettype wire

>>> tb/timestamp_range_log_store_tb.sv
// Self-checking testbench for timestamp_range_log_store: directed and random puts and
// range retrieves, randomly idled on both channels, checked word by word by a scoreboard.
// Depends on tsrl_pkg, tsrl_if and the RTL of the store.
`default_nettype none

module timestamp_range_log_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsrl_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 110;
    localparam logic [GRAN_W-1:0] GR_SECOND = 3'd5;

    typedef struct {
        bit [ID_W-1:0] id;
        bit [ST_W-1:0] status;
        bit            last;
    } t_word;

    typedef struct {
        bit [KEY_W-1:0] key;
        bit [ID_W-1:0]  id;
    } t_hit;

    class log_store_scoreboard;
        bit [KEY_W-1:0] slot_key  [CAPACITY];
        bit [ID_W-1:0]  slot_id   [CAPACITY];
        bit             slot_used [CAPACITY];
        t_word          awaited   [$];
        int             errors;

        function bit [KEY_W-1:0] key_mask(bit [GRAN_W-1:0] g);
            int drop;
            case (g)
                GR_YEAR:   drop = 26;
                GR_MONTH:  drop = 22;
                GR_DAY:    drop = 17;
                GR_HOUR:   drop = 12;
                GR_MINUTE: drop = 6;
                default:   drop = 0;
            endcase
            return {KEY_W{1'b1}} << drop;
        endfunction

        function void push_word(bit [ID_W-1:0] id, bit [ST_W-1:0] status, bit last);
            t_word w;
            w.id     = id;
            w.status = status;
            w.last   = last;
            awaited.insert(awaited.size(), w);
        endfunction

        function void store_id(bit [ID_W-1:0] id, bit [KEY_W-1:0] key);
            int free_slot;
            free_slot = -1;
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_used[i] && slot_key[i] == key) begin
                    slot_id[i] = id;
                    push_word('0, ST_REPLACED, 1'b1);
                    return;
                end
                if (!slot_used[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot < 0) begin
                push_word('0, ST_FULL, 1'b1);
                return;
            end
            slot_key[free_slot]  = key;
            slot_id[free_slot]   = id;
            slot_used[free_slot] = 1'b1;
            push_word('0, ST_NEW, 1'b1);
        endfunction

        function void find_range(bit [KEY_W-1:0] lo, bit [KEY_W-1:0] hi,
                                 bit [GRAN_W-1:0] g);
            bit [KEY_W-1:0] m;
            bit [KEY_W-1:0] t;
            t_hit           hits [$];
            t_hit           h;
            int             j;
            m = key_mask(g);
            for (int i = 0; i < CAPACITY; i++) begin
                if (!slot_used[i]) continue;
                t = slot_key[i] & m;
                if (t >= (lo & m) && t <= (hi & m)) begin
                    h.key = slot_key[i];
                    h.id  = slot_id[i];
                    j = 0;
                    while (j < hits.size() && hits[j].key < h.key) j++;
                    hits.insert(j, h);
                end
            end
            if (hits.size() == 0) begin
                push_word('0, ST_NONE, 1'b1);
                return;
            end
            foreach (hits[k]) push_word(hits[k].id, ST_MATCH, k == hits.size() - 1);
        endfunction

        function void note_request(bit op, bit [ID_W-1:0] id, bit [KEY_W-1:0] stamp,
                                   bit [KEY_W-1:0] end_stamp, bit [GRAN_W-1:0] g);
            if (op == OP_PUT) store_id(id, stamp);
            else find_range(stamp, end_stamp, g);
        endfunction

        function void compare(string field, longint unsigned expv, longint unsigned actv);
            if (expv != actv) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, expv, actv);
                errors++;
            end
        endfunction

        function void check_word(bit [ID_W-1:0] id, bit [ST_W-1:0] status, bit last);
            t_word w;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual id %0d status %0d last %0d",
                         $time, id, status, last);
                errors++;
                return;
            end
            w = awaited.pop_front();
            compare("result_id", w.id, id);
            compare("status", w.status, status);
            compare("last", w.last, last);
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   no_gaps = 1'b0;

    tsrl_in_if  req_if ();
    tsrl_out_if rsp_if ();

    log_store_scoreboard sb = new;
    bit [KEY_W-1:0]      put_keys [$];

    timestamp_range_log_store #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit [KEY_W-1:0] rand40();
        bit [63:0] r;
        r = {$urandom, $urandom};
        return r[KEY_W-1:0];
    endfunction

    function automatic bit [KEY_W-1:0] make_stamp(int y, int mo, int d, int h, int mi, int s);
        return {y[13:0], mo[3:0], d[4:0], h[4:0], mi[5:0], s[5:0]};
    endfunction

    function automatic bit [KEY_W-1:0] rand_stamp();
        if ($urandom_range(0, 7) == 0) return rand40();
        return make_stamp($urandom_range(2020, 2023), $urandom_range(0, 15),
                          $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 63), $urandom_range(0, 63));
    endfunction

    function automatic bit [KEY_W-1:0] pick_key();
        if (put_keys.size() == 0 || $urandom_range(0, 3) == 0) return rand_stamp();
        return put_keys[$urandom_range(0, put_keys.size() - 1)];
    endfunction

    // called and returns at a falling edge
    task automatic send_request(bit op, bit [ID_W-1:0] id, bit [KEY_W-1:0] stamp,
                                bit [KEY_W-1:0] end_stamp, bit [GRAN_W-1:0] g);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.operation   = op;
        req_if.log_id      = id;
        req_if.stamp       = stamp;
        req_if.end_stamp   = end_stamp;
        req_if.granularity = g;
        req_if.valid       = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(op, id, stamp, end_stamp, g);
        if (op == OP_PUT) put_keys.insert(put_keys.size(), stamp);
        @(negedge i_clk);
    endtask

    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall != 0) begin
                rsp_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            sb.check_word(rsp_if.result_id, rsp_if.status, rsp_if.last);
            @(negedge i_clk);
        end
    end

    initial begin
        #5ms;
        $display("** timestamp_range_log_store: FAILED **");
        $finish;
    end

    initial begin
        bit [KEY_W-1:0] k1;
        bit [KEY_W-1:0] lo;
        bit [KEY_W-1:0] hi;
        bit [KEY_W-1:0] tmp;
        int             mode;
        int             shifts [6];

        shifts = '{0, 6, 12, 17, 22, 26};
        req_if.valid       = 1'b0;
        req_if.operation   = OP_PUT;
        req_if.log_id      = '0;
        req_if.stamp       = '0;
        req_if.end_stamp   = '0;
        req_if.granularity = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, extremes, replace, one step in each field
        send_request(OP_RETRIEVE, '0, '0, '1, GR_SECOND);
        send_request(OP_PUT, '0, '0, '1, 3'd7);
        send_request(OP_PUT, '1, '1, '0, GR_YEAR);
        send_request(OP_PUT, 31'd123, '0, '0, GR_SECOND);
        k1 = make_stamp(2021, 6, 15, 10, 30, 45);
        send_request(OP_PUT, 31'd1000, k1, '0, GR_SECOND);
        foreach (shifts[i])
            send_request(OP_PUT, ID_W'(2000 + i), k1 + (40'd1 << shifts[i]), '0, GR_SECOND);
        for (int g = 0; g < 8; g++)
            send_request(OP_RETRIEVE, '0, k1, k1, GRAN_W'(g));
        send_request(OP_RETRIEVE, '0, k1 + 40'd1, k1, GR_SECOND);
        send_request(OP_RETRIEVE, '1, '0, '1, GR_YEAR);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_gaps = (n >= 50 && n < 70);
            if ($urandom_range(0, 9) < 7) begin
                tmp = (put_keys.size() != 0 && $urandom_range(0, 4) == 0)
                      ? put_keys[$urandom_range(0, put_keys.size() - 1)] : rand_stamp();
                send_request(OP_PUT, ID_W'($urandom), tmp, rand40(),
                             GRAN_W'($urandom_range(0, 7)));
            end else begin
                mode = $urandom_range(0, 7);
                if (mode == 0) begin
                    lo = rand40();
                    hi = rand40();
                end else begin
                    lo = pick_key();
                    hi = pick_key();
                    // mode 1 keeps an inverted range
                    if ((lo > hi) != (mode == 1)) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end
                send_request(OP_RETRIEVE, ID_W'($urandom), lo, hi,
                             GRAN_W'($urandom_range(0, 7)));
            end
        end
        no_gaps = 1'b0;
        req_if.valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** timestamp_range_log_store: PASSED **");
        end else begin
            $display("** timestamp_range_log_store: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
